### rtl/hlv_pkg.sv
// ----------------------------------------------------------------------------
// hlv_pkg: shared types and constants of the Hough line vote unit
// Request/result structs, sequencer states, fixed widths and the Q2.14
// quarter-wave sine generator used to build the trig table at elaboration.
// ----------------------------------------------------------------------------
package hlv_pkg;

  // Defaults of the top-level parameters
  localparam int DEF_RHO_OFFSET  = 255;
  localparam int DEF_ANGLE_STEPS = 180;

  // Fixed field and datapath widths
  localparam int COUNT_W     = 17;
  localparam int DROP_W      = 8;
  localparam int SIN_W       = 16;
  localparam int ACC_W       = 26;
  localparam int ROW_SW      = 12;
  localparam int Q_FRAC      = 14;
  localparam int QUARTER_DEG = 90;
  localparam int ROM_IDX_W   = 7;

  localparam logic [7:0]         EDGE_VALUE = 8'd255;
  localparam logic [COUNT_W-1:0] COUNT_MAX  = {COUNT_W{1'b1}};
  localparam logic [DROP_W-1:0]  DROP_MAX   = {DROP_W{1'b1}};

  // Request opcodes
  localparam logic OP_VOTE = 1'b0;
  localparam logic OP_READ = 1'b1;

  // pi in Q32
  localparam longint PI_Q32 = 64'sd13493037705;

  typedef struct packed {
    logic       opcode;
    logic [7:0] pixel_x;
    logic [7:0] pixel_y;
    logic [7:0] pixel_value;
    logic [8:0] read_rho;
    logic [7:0] read_angle;
  } hlv_req_t;

  typedef struct packed {
    logic [COUNT_W-1:0] cell_count;
    logic [DROP_W-1:0]  dropped_votes;
  } hlv_res_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_VOTE,
    ST_DRAIN,
    ST_READ,
    ST_FINISH
  } hlv_state_t;

  // round(16384 * sin(d deg)) for d in 0..90, Taylor series in Q30.
  // Eleven terms; each of the ten divisors (2n)(2n+1) is written out.
  // Only called with constant arguments, so it folds to a table.
  function automatic logic signed [SIN_W-1:0] sine_q14_quarter(input int d);
    longint x;
    longint x2;
    longint term;
    longint sum;
    longint rounded;
    x    = (longint'(d) * PI_Q32 + 64'sd360) / 64'sd720;
    x2   = (x * x) >>> 30;
    term = ((x * x2) >>> 30) / 64'sd6;
    sum  = x - term;
    term = ((term * x2) >>> 30) / 64'sd20;
    sum  = sum + term;
    term = ((term * x2) >>> 30) / 64'sd42;
    sum  = sum - term;
    term = ((term * x2) >>> 30) / 64'sd72;
    sum  = sum + term;
    term = ((term * x2) >>> 30) / 64'sd110;
    sum  = sum - term;
    term = ((term * x2) >>> 30) / 64'sd156;
    sum  = sum + term;
    term = ((term * x2) >>> 30) / 64'sd210;
    sum  = sum - term;
    term = ((term * x2) >>> 30) / 64'sd272;
    sum  = sum + term;
    term = ((term * x2) >>> 30) / 64'sd342;
    sum  = sum - term;
    term = ((term * x2) >>> 30) / 64'sd420;
    sum  = sum + term;
    rounded = (sum + 64'sd32768) >>> 16;
    return rounded[SIN_W-1:0];
  endfunction

endpackage

### rtl/hough_line_vote_unit.sv
// ----------------------------------------------------------------------------
// hough_line_vote_unit: Hough line accumulator, voting and readout
// Accumulates line votes per (rho, angle) cell and returns cell counts.
// ----------------------------------------------------------------------------
// Usage:
//   Requests arrive on req_valid/req_ready/req_data, one result per request
//   leaves on res_valid/res_ready/res_data.
//   A vote request whose pixel_value is 255 walks all ANGLE_STEPS angles
//   through one shared projection unit, one angle per cycle, and does a
//   read-modify-write of one accumulator cell per angle. After the accept
//   and the angle walk, the projection, address, read and write stages
//   drain, and then the result register is loaded.
//   Any other vote request goes straight to the finish state; a read request
//   first passes a read state, as the accumulator read port is registered.
//   The block takes one request at a time; req_ready is low while busy.
//   After reset the accumulator (2*RHO_OFFSET*ANGLE_STEPS cells, 91800 at
//   the defaults) is cleared one cell per cycle; req_ready stays low until
//   the clear sweep is done.
//   A finished result sits in an output register; the next request is taken
//   while it waits, and only the following result waits for res_ready.
// ----------------------------------------------------------------------------
module hough_line_vote_unit
  import hlv_pkg::*;
#(
  parameter int RHO_OFFSET  = DEF_RHO_OFFSET,
  parameter int ANGLE_STEPS = DEF_ANGLE_STEPS
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     req_valid,
  output logic     req_ready,
  input  hlv_req_t req_data,
  output logic     res_valid,
  input  logic     res_ready,
  output hlv_res_t res_data
);

  localparam int ROW_COUNT = 2 * RHO_OFFSET;
  localparam int DEPTH     = ROW_COUNT * ANGLE_STEPS;
  localparam int ADDR_W    = $clog2(DEPTH);
  localparam int ROW_IDX_W = $clog2(ROW_COUNT);
  localparam int ANG_W     = $clog2(ANGLE_STEPS);

  localparam logic [ADDR_W-1:0] LAST_ADDR  = ADDR_W'(DEPTH - 1);
  localparam logic [ANG_W-1:0]  LAST_ANGLE = ANG_W'(ANGLE_STEPS - 1);

  hlv_state_t state;
  hlv_state_t state_next;

  logic                    accept;
  logic                    issue;
  logic                    load_res;
  logic                    clr_we;
  logic [ADDR_W-1:0]       clr_addr;

  logic [7:0]              px;
  logic [7:0]              py;
  logic [ANG_W-1:0]        angle;

  logic                    acc_valid;
  logic signed [ACC_W-1:0] acc;
  logic [ANG_W-1:0]        acc_angle;

  logic                    acc_neg;
  logic [ACC_W-1:0]        acc_mag;
  logic signed [ROW_SW-1:0] rho_mag;
  logic signed [ROW_SW-1:0] rho;
  logic signed [ROW_SW-1:0] row;
  logic                    row_ok;
  logic [ADDR_W-1:0]       vote_addr;

  logic                    v2;
  logic [ADDR_W-1:0]       addr2;
  logic                    v3;
  logic [ADDR_W-1:0]       addr3;

  logic                    read_ok;
  logic [ADDR_W-1:0]       read_addr;
  logic                    rd_ok;

  logic [DROP_W-1:0]       drop_cnt;
  logic [COUNT_W-1:0]      hold_count;

  logic [COUNT_W-1:0]      mem [0:DEPTH-1];
  logic [COUNT_W-1:0]      rdata;
  logic                    mem_we;
  logic [ADDR_W-1:0]       mem_waddr;
  logic [COUNT_W-1:0]      mem_wdata;
  logic [ADDR_W-1:0]       mem_raddr;

  assign accept = req_valid && req_ready;

  // Shared projection unit
  hlv_rho_unit #(
    .ANGLE_STEPS(ANGLE_STEPS)
  ) u_rho (
    .clk      (clk),
    .rst      (rst),
    .issue    (issue),
    .pixel_x  (px),
    .pixel_y  (py),
    .angle    (angle),
    .acc_valid(acc_valid),
    .acc      (acc),
    .acc_angle(acc_angle)
  );

  // Truncate toward zero, offset, range check, cell address
  always_comb begin
    acc_neg   = acc[ACC_W-1];
    acc_mag   = acc_neg ? -acc : acc;
    rho_mag   = ROW_SW'(acc_mag >> Q_FRAC);
    rho       = acc_neg ? -rho_mag : rho_mag;
    row       = rho + ROW_SW'(RHO_OFFSET);
    row_ok    = !row[ROW_SW-1] && (row < $signed(ROW_SW'(ROW_COUNT)));
    vote_addr = ADDR_W'(row[ROW_IDX_W-1:0]) * ADDR_W'(ANGLE_STEPS) + ADDR_W'(acc_angle);
  end

  // Readout address of a read request
  always_comb begin
    read_ok   = ({3'b000, req_data.read_rho} < 12'(ROW_COUNT)) &&
                ({1'b0, req_data.read_angle} < 9'(ANGLE_STEPS));
    read_addr = ADDR_W'(req_data.read_rho) * ADDR_W'(ANGLE_STEPS) +
                ADDR_W'(req_data.read_angle);
  end

  // Sequencer: next state and controls
  always_comb begin
    state_next = state;
    req_ready  = 1'b0;
    issue      = 1'b0;
    load_res   = 1'b0;
    clr_we     = 1'b0;
    case (state)
      ST_CLEAR: begin
        clr_we = 1'b1;
        if (clr_addr == LAST_ADDR) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          if (req_data.opcode == OP_READ) begin
            state_next = ST_READ;
          end else if (req_data.pixel_value == EDGE_VALUE) begin
            state_next = ST_VOTE;
          end else begin
            state_next = ST_FINISH;
          end
        end
      end
      ST_VOTE: begin
        issue = 1'b1;
        if (angle == LAST_ANGLE) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!acc_valid && !v2 && !v3) begin
          state_next = ST_FINISH;
        end
      end
      ST_READ: begin
        state_next = ST_FINISH;
      end
      ST_FINISH: begin
        if (!res_valid || res_ready) begin
          load_res   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_CLEAR;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      clr_addr  <= '0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (clr_we) begin
        clr_addr <= clr_addr + 1'b1;
      end
      v2 <= acc_valid && row_ok;
      v3 <= v2;
      if (load_res) begin
        res_valid <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  // Request, angle walk, drop count and result payload
  always_ff @(posedge clk) begin
    if (accept) begin
      px         <= req_data.pixel_x;
      py         <= req_data.pixel_y;
      rd_ok      <= read_ok;
      drop_cnt   <= '0;
      hold_count <= '0;
      angle      <= '0;
    end else begin
      if (issue) begin
        angle <= angle + 1'b1;
      end
      if (acc_valid && !row_ok && (drop_cnt != DROP_MAX)) begin
        drop_cnt <= drop_cnt + 1'b1;
      end
      if (state == ST_READ) begin
        hold_count <= rd_ok ? rdata : '0;
      end
    end
    addr2 <= vote_addr;
    addr3 <= addr2;
    if (load_res) begin
      res_data.cell_count    <= hold_count;
      res_data.dropped_votes <= drop_cnt;
    end
  end

  // Accumulator port muxing: clear sweep or saturating increment
  always_comb begin
    mem_we    = clr_we || v3;
    mem_waddr = clr_we ? clr_addr : addr3;
    if (clr_we) begin
      mem_wdata = '0;
    end else if (rdata == COUNT_MAX) begin
      mem_wdata = rdata;
    end else begin
      mem_wdata = rdata + 1'b1;
    end
    mem_raddr = (state == ST_IDLE) ? read_addr : addr2;
  end

  // Accumulator memory: one write, one registered read per cycle
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rdata <= mem[mem_raddr];
  end

endmodule

### rtl/hlv_rho_unit.sv
// ----------------------------------------------------------------------------
// hlv_rho_unit: shared per-angle projection unit
// Looks up cos/sin of one angle from the quarter-wave table and forms
// x*cos + y*sin in Q14. One angle per cycle, result registered.
// ----------------------------------------------------------------------------
module hlv_rho_unit
  import hlv_pkg::*;
#(
  parameter int ANGLE_STEPS = DEF_ANGLE_STEPS,
  localparam int ANG_W = $clog2(ANGLE_STEPS)
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    issue,
  input  logic [7:0]              pixel_x,
  input  logic [7:0]              pixel_y,
  input  logic [ANG_W-1:0]        angle,
  output logic                    acc_valid,
  output logic signed [ACC_W-1:0] acc,
  output logic [ANG_W-1:0]        acc_angle
);

  // Quarter-wave sine table, constant after elaboration
  logic signed [SIN_W-1:0] quarter_rom [0:QUARTER_DEG];

  for (genvar g = 0; g <= QUARTER_DEG; g++) begin : g_rom
    localparam logic signed [SIN_W-1:0] SINE_Q14 = sine_q14_quarter(g);
    assign quarter_rom[g] = SINE_Q14;
  end

  // Fold a degree value in 0..359 onto the quarter wave: {negate, index}
  function automatic logic [ROM_IDX_W:0] deg_fold(input logic [8:0] d);
    logic [8:0] idx;
    logic       neg;
    if (d <= 9'd90) begin
      idx = d;
      neg = 1'b0;
    end else if (d <= 9'd180) begin
      idx = 9'd180 - d;
      neg = 1'b0;
    end else if (d <= 9'd270) begin
      idx = d - 9'd180;
      neg = 1'b1;
    end else begin
      idx = 9'd360 - d;
      neg = 1'b1;
    end
    return {neg, idx[ROM_IDX_W-1:0]};
  endfunction

  logic [8:0]                deg_sin;
  logic [8:0]                deg_cos;
  logic [ROM_IDX_W:0]        sin_f;
  logic [ROM_IDX_W:0]        cos_f;
  logic signed [SIN_W-1:0]   sin_v;
  logic signed [SIN_W-1:0]   cos_v;
  logic signed [24:0]        prod_x;
  logic signed [24:0]        prod_y;
  logic signed [ACC_W-1:0]   acc_next;

  // Trig lookup and multiply-add
  always_comb begin
    deg_sin = 9'(angle);
    deg_cos = deg_sin + 9'd90;
    if (deg_cos >= 9'd360) begin
      deg_cos = deg_cos - 9'd360;
    end
    sin_f  = deg_fold(deg_sin);
    cos_f  = deg_fold(deg_cos);
    sin_v  = sin_f[ROM_IDX_W] ? -quarter_rom[sin_f[ROM_IDX_W-1:0]]
                              :  quarter_rom[sin_f[ROM_IDX_W-1:0]];
    cos_v  = cos_f[ROM_IDX_W] ? -quarter_rom[cos_f[ROM_IDX_W-1:0]]
                              :  quarter_rom[cos_f[ROM_IDX_W-1:0]];
    prod_x = $signed({1'b0, pixel_x}) * cos_v;
    prod_y = $signed({1'b0, pixel_y}) * sin_v;
    acc_next = ACC_W'(prod_x) + ACC_W'(prod_y);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc_valid <= 1'b0;
    end else begin
      acc_valid <= issue;
    end
  end

  always_ff @(posedge clk) begin
    acc       <= acc_next;
    acc_angle <= angle;
  end

endmodule
